// File: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SDF_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdf assertion failed");

// Same, on the house clock and reset names.
`define SDF_ASSERT(name, prop) \
  `SDF_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

// File: design/sdf_pkg.sv
// Package for the stream duplicate filter: widths and default sizes.
package sdf_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned EpochWidth = 8;

  typedef logic [ValueWidth-1:0] value_t;

endpackage

// File: design/sdf_if.sv
// Stream interfaces of the duplicate filter: input word and result word channels.
interface sdf_in_if;
  logic              valid;
  logic              ready;
  sdf_pkg::value_t   value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface sdf_out_if;
  logic              valid;
  logic              ready;
  sdf_pkg::value_t   value_out;
  logic              keep;
  logic              last_out;
  logic              overflow;

  modport source (output valid, output value_out, output keep, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input value_out, input keep, input last_out,
                  input overflow, output ready);
endinterface

// File: design/sdf_ram.sv
// Generic single-port RAM with registered read data.
module sdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [Width-1:0]     wdata_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/stream_duplicate_filter.sv
// Stream duplicate filter: flags the first occurrence of each key within a list.
//
// Input channel in_i carries one list element per word (value, last). Output
// channel out_o returns one word per input: the value unchanged, keep = 1 on
// the first occurrence of its key in the current list, last_out copied, and
// overflow = 1 when a new key found no free slot in the table.
// Keys live in an open-addressed hash table in one single-port RAM, one entry
// per slot tagged with a list epoch; slots of an older epoch count as empty.
// Each probe is a RAM read in ST_READ plus a compare in ST_CMP. An element's
// result goes to the output register once a probe settles it, the first probe
// or a later one, up to TableDepth probes when the table is full.
// One element is in work at a time, so no new element is accepted before the
// last one is through; the next is accepted once the previous result sits in the
// output register, even while the receiver stalls it.
// A stalled receiver holds the result, and the next element waits before its
// first probe until the output register is free.
// Reset starts a clearing sweep of all TableDepth slots with in_i.ready low. The
// same sweep runs after every 255th list, when the epoch tag wraps.
module stream_duplicate_filter #(
  parameter int unsigned TableDepth = sdf_pkg::TableDepth,
  parameter int unsigned KeyWidth   = sdf_pkg::KeyWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdf_in_if.sink    in_i,
  sdf_out_if.source out_o
);

  localparam int unsigned AddrWidth = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned EpochW    = sdf_pkg::EpochWidth;
  localparam int unsigned WordW     = EpochW + KeyWidth;
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(TableDepth - 1);
  localparam logic [EpochW-1:0]    EpochMax = '1;
  localparam logic [EpochW-1:0]    EpochFirst = EpochW'(1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CMP   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [AddrWidth-1:0]  idx_q, idx_d;
  logic [AddrWidth-1:0]  probe_q, probe_d;
  logic [EpochW-1:0]     epoch_q, epoch_d;
  sdf_pkg::value_t       value_q, value_d;
  logic                  last_q, last_d;

  logic                  out_valid_q, out_valid_d;
  sdf_pkg::value_t       out_value_q, out_value_d;
  logic                  out_keep_q, out_keep_d;
  logic                  out_last_q, out_last_d;
  logic                  out_ovf_q, out_ovf_d;

  logic                  mem_en, mem_we;
  logic [WordW-1:0]      mem_wdata, mem_rdata;

  logic [AddrWidth-1:0]  hash_raw, hash_idx;
  logic [KeyWidth-1:0]   key_in, key_q;
  logic [EpochW-1:0]     rd_epoch;
  logic [KeyWidth-1:0]   rd_key;
  logic                  hit, empty, done;
  logic [AddrWidth-1:0]  idx_next;

  assign key_in   = in_i.value[KeyWidth-1:0];
  assign key_q    = value_q[KeyWidth-1:0];
  assign rd_epoch = mem_rdata[WordW-1:KeyWidth];
  assign rd_key   = mem_rdata[KeyWidth-1:0];
  assign idx_next = (idx_q == LastAddr) ? '0 : idx_q + AddrWidth'(1);

  // xor fold of the key onto the slot index, then one fold into range
  always_comb begin
    hash_raw = '0;
    for (int i = 0; i < KeyWidth; i++) begin
      hash_raw[i % AddrWidth] = hash_raw[i % AddrWidth] ^ key_in[i];
    end
    if ({1'b0, hash_raw} >= (AddrWidth + 1)'(TableDepth)) begin
      hash_idx = hash_raw - AddrWidth'(TableDepth);
    end else begin
      hash_idx = hash_raw;
    end
  end

  assign hit   = (rd_epoch == epoch_q) && (rd_key == key_q);
  assign empty = (rd_epoch != epoch_q);
  assign done  = hit || empty || (probe_q == LastAddr);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    probe_d     = probe_q;
    epoch_d     = epoch_q;
    value_d     = value_q;
    last_d      = last_q;
    out_value_d = out_value_q;
    out_keep_d  = out_keep_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = {epoch_q, key_q};

    case (state_q)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (idx_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_next;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          value_d = in_i.value;
          last_d  = in_i.last;
          idx_d   = hash_idx;
          probe_d = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // wait for a free output register before probing
        if (!out_valid_q || out_o.ready) begin
          mem_en  = 1'b1;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (done) begin
          out_valid_d = 1'b1;
          out_value_d = value_q;
          out_keep_d  = !hit;
          out_last_d  = last_q;
          out_ovf_d   = !hit && !empty;
          if (empty) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
          end
          state_d = ST_IDLE;
          if (last_q) begin
            if (epoch_q == EpochMax) begin
              epoch_d = EpochFirst;
              idx_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EpochW'(1);
            end
          end
        end else begin
          idx_d   = idx_next;
          probe_d = probe_q + AddrWidth'(1);
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      probe_q     <= '0;
      epoch_q     <= EpochFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      probe_q     <= probe_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    last_q      <= last_d;
    out_value_q <= out_value_d;
    out_keep_q  <= out_keep_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  sdf_ram #(
    .Width (WordW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (idx_q),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = out_value_q;
  assign out_o.keep      = out_keep_q;
  assign out_o.last_out  = out_last_q;
  assign out_o.overflow  = out_ovf_q;

endmodule

// File: design/sdf_checker.sv
// Port-level checker for the stream duplicate filter, bound to the top level.
`include "assert_macros.svh"

module sdf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_keep_i,
  input logic out_overflow_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  `SDF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `SDF_ASSERT(a_busy_after_accept, in_acc |=> !in_ready_i)
  `SDF_ASSERT(a_min_latency, in_acc |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i))
  `SDF_ASSERT(a_repeat_no_ovf, out_valid_i && !out_keep_i |-> !out_overflow_i)

endmodule

bind stream_duplicate_filter sdf_checker u_sdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_keep_i     (out_o.keep),
  .out_overflow_i (out_o.overflow)
);
